@@ design/b64e_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the Base64 alphabet for the line-wrapping
// encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;
  localparam logic [7:0] CHAR_LINE_FEED    = 8'h0A;
  localparam logic [7:0] CHAR_PAD          = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS         = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH        = 8'h2F;  // '/'

  // Position in the 3-byte group
  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_e;

  // One request from the front to the back: one or two data codes, then
  // up to two pads. The column restarts after it when end of data is set.
  typedef struct packed {
    logic [1:0][5:0] codes;
    logic [1:0]      n_codes;
    logic [1:0]      n_pads;
    logic            eod;
  } job_t;

  function automatic logic [7:0] code_to_ascii(input logic [5:0] code);
    logic [7:0] c;
    c = {2'b00, code};
    if (code < 6'd26)       return 8'(8'd65 + c);          // 'A'
    else if (code < 6'd52)  return 8'(8'd97 + c - 8'd26);  // 'a'
    else if (code < 6'd62)  return 8'(8'd48 + c - 8'd52);  // '0'
    else if (code == 6'd62) return CHAR_PLUS;
    else                    return CHAR_SLASH;
  endfunction

endpackage

@@ design/b64e_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Takes raw bytes, splits them into 6-bit codes and works out the flush
// and padding on the final byte.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          full_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_data_i,
  output logic          wr_en_o,
  output b64e_pkg::job_t job_o
);
  import b64e_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  job_t       job;

  assign wr_en_o = push_i && !full_i;
  assign job_o   = job;

  always_comb begin
    job         = '0;
    job.eod     = end_of_data_i;
    job.n_codes = 2'd1;
    phase_d     = phase_q;
    left_d      = left_q;
    case (phase_q)
      PH_1: begin
        job.codes[0] = {left_q[1:0], data_byte_i[7:4]};
        left_d       = data_byte_i[3:0];
        phase_d      = PH_2;
      end
      PH_2: begin
        job.codes[0] = {left_q[3:0], data_byte_i[7:6]};
        job.codes[1] = data_byte_i[5:0];
        job.n_codes  = 2'd2;
        left_d       = 4'd0;
        phase_d      = PH_0;
      end
      default: begin
        job.codes[0] = data_byte_i[7:2];
        left_d       = {2'b00, data_byte_i[1:0]};
        phase_d      = PH_1;
      end
    endcase

    if (end_of_data_i) begin
      // Flush the partial group; missing low bits are zero
      if (phase_d == PH_1) begin
        job.codes[1] = {left_d[1:0], 4'd0};
        job.n_codes  = 2'd2;
        job.n_pads   = 2'd2;
      end else if (phase_d == PH_2) begin
        job.codes[1] = {left_d[3:0], 2'd0};
        job.n_codes  = 2'd2;
        job.n_pads   = 2'd1;
      end
      left_d  = 4'd0;
      phase_d = PH_0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_0;
      left_q  <= 4'd0;
    end else if (wr_en_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

@@ design/b64e_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module b64e_fifo #(
  parameter int unsigned Depth = b64e_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  b64e_pkg::job_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output logic           valid_o,
  output b64e_pkg::job_t rd_data_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (rd_en_i) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (wr_en_i && !rd_en_i)      cnt_q <= CntW'(cnt_q + 1'b1);
      else if (!wr_en_i && rd_en_i) cnt_q <= CntW'(cnt_q - 1'b1);
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en_i && full_o))
    else $error("request queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en_i && !valid_o))
    else $error("request queue read while empty");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("request queue count out of range");

endmodule

@@ design/b64e_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Emits one character a cycle per request while the output is empty or popped:
// data characters with line feeds at the line length, then pads. Holds the column count.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     line_length_i,
  input  logic           req_valid_i,
  input  b64e_pkg::job_t req_i,
  output logic           req_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     out_char_o,
  output logic           last_of_run_o
);
  import b64e_pkg::*;

  job_t       job_q, job_d;
  logic       busy_q, busy_d;
  logic [1:0] emitted_q, emitted_d;
  logic [1:0] pads_q, pads_d;
  logic       lf_q, lf_d;
  logic [7:0] col_q, col_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;

  logic       emit, job_done, load, wrap;
  logic [7:0] col_inc;

  assign empty_o       = !out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_of_run_o = out_last_q;
  assign req_pop_o     = load;

  always_comb begin
    job_d       = job_q;
    busy_d      = busy_q;
    emitted_d   = emitted_q;
    pads_d      = pads_q;
    lf_d        = lf_q;
    col_d       = col_q;
    out_valid_d = out_valid_q && !pop_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    job_done    = 1'b0;
    col_inc     = 8'(col_q + 1'b1);
    wrap        = (col_inc >= line_length_i);

    emit = busy_q && (!out_valid_q || pop_i);
    if (emit) begin
      out_valid_d = 1'b1;
      if (lf_q) begin
        out_char_d = CHAR_LINE_FEED;
        out_last_d = (emitted_q == job_q.n_codes) && (pads_q == 2'd0);
        lf_d       = 1'b0;
      end else if (emitted_q != job_q.n_codes) begin
        out_char_d = code_to_ascii(job_q.codes[emitted_q[0]]);
        emitted_d  = 2'(emitted_q + 1'b1);
        out_last_d = !wrap && (emitted_d == job_q.n_codes) && (pads_q == 2'd0);
        if (wrap) begin
          lf_d  = 1'b1;
          col_d = 8'd0;
        end else begin
          col_d = col_inc;
        end
      end else begin
        // pads never move the column
        out_char_d = CHAR_PAD;
        out_last_d = (pads_q == 2'd1);
        pads_d     = 2'(pads_q - 1'b1);
      end
      job_done = out_last_d;
    end

    if (job_done && job_q.eod) col_d = 8'd0;

    load = req_valid_i && (!busy_q || job_done);
    if (load) begin
      job_d     = req_i;
      busy_d    = 1'b1;
      emitted_d = 2'd0;
      pads_d    = req_i.n_pads;
      lf_d      = 1'b0;
    end else if (job_done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      emitted_q   <= 2'd0;
      pads_q      <= 2'd0;
      lf_q        <= 1'b0;
      col_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      emitted_q   <= emitted_d;
      pads_q      <= pads_d;
      lf_q        <= lf_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_lf_col_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lf_q |-> (col_q == 8'd0))
    else $error("line feed pending with non-zero column");

  a_emit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (emitted_q <= job_q.n_codes) && (job_q.n_codes != 2'd0))
    else $error("data code index beyond request");

  a_pad_after_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_char_d == CHAR_PAD) |-> (emitted_q == job_q.n_codes) && !lf_q)
    else $error("pad emitted before data or line feed");

endmodule

@@ design/base64_encoder_line_wrap.sv @@
`timescale 1ns / 1ps
// Path: an accepted byte goes through the request queue and the back end's
// request register; its first character is then registered onto the result
// ports. Throughput: the back end emits one character per cycle while its
// output is empty or popped; a byte yields 1 to 6 characters (about 1.4 on average).
// Reset: asynchronous, active low; line length returns to 76, queues empty.
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// Base64 encoder with MIME-style line wrapping and end-of-data padding.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap #(
  parameter int unsigned QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       line_length_we_i,
  input  logic [7:0] line_length_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_data_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       last_of_run_o
);
  import b64e_pkg::*;

  logic [7:0] line_length_q;
  logic       wr_en, req_valid, req_pop;
  job_t       wr_job, req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= LINE_LENGTH_RESET;
    end else if (line_length_we_i) begin
      line_length_q <= line_length_i;
    end
  end

  b64e_front u_front (
    .clk_i,
    .rst_ni,
    .push_i        (push),
    .full_i        (full),
    .data_byte_i,
    .end_of_data_i,
    .wr_en_o       (wr_en),
    .job_o         (wr_job)
  );

  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .wr_en_i   (wr_en),
    .wr_data_i (wr_job),
    .full_o    (full),
    .rd_en_i   (req_pop),
    .valid_o   (req_valid),
    .rd_data_o (req)
  );

  b64e_back u_back (
    .clk_i,
    .rst_ni,
    .line_length_i (line_length_q),
    .req_valid_i   (req_valid),
    .req_i         (req),
    .req_pop_o     (req_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_char_o,
    .last_of_run_o
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Base64 encoder with line wrapping. Bytes are
// pushed in random bursts and the characters popped under a changing stall
// pattern. A scoreboard predicts every character, line feed and pad, and each
// popped character is compared against it.
// ----------------------------------------------------------------------------
module tb;
  import b64e_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int STALL_MAX  = 1000;  // cycles with no request moving at all
  localparam int LONG_HOLD  = 150;
  localparam int SETTLE     = 4;

  typedef enum int {
    POP_ALWAYS,
    POP_RANDOM,
    POP_SPARSE,
    POP_TOGGLE
  } pop_mode_e;

  // Predicts the character stream and holds what is still to come.
  class b64_scoreboard;
    typedef struct packed {
      logic [7:0] ch;
      logic       last;
    } char_t;

    char_t      pending[$];
    logic [7:0] line_len;
    logic [3:0] carry;
    phase_e     phase;
    logic [7:0] column;
    int         errors;
    string      alphabet;

    function new();
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      line_len = LINE_LENGTH_RESET;
      carry    = '0;
      phase    = PH_0;
      column   = '0;
      errors   = 0;
    endfunction

    function void set_line_length(logic [7:0] v);
      line_len = v;
    endfunction

    function void emit(logic [7:0] ch);
      char_t c;
      c.ch   = ch;
      c.last = 1'b0;
      pending.push_back(c);
    endfunction

    function void emit_code(logic [5:0] code);
      emit(8'(alphabet[code]));
      column = column + 8'd1;
      if (column >= line_len) begin
        emit(CHAR_LINE_FEED);
        column = '0;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eod);
      case (phase)
        PH_1: begin
          emit_code({carry[1:0], b[7:4]});
          carry = b[3:0];
          phase = PH_2;
        end
        PH_2: begin
          emit_code({carry, b[7:6]});
          emit_code(b[5:0]);
          carry = '0;
          phase = PH_0;
        end
        default: begin
          emit_code(b[7:2]);
          carry = {2'b00, b[1:0]};
          phase = PH_1;
        end
      endcase
      if (eod) begin
        // flushed code first; any line feed it causes goes ahead of the pads
        if (phase == PH_1) begin
          emit_code({carry[1:0], 4'b0000});
          emit(CHAR_PAD);
          emit(CHAR_PAD);
        end else if (phase == PH_2) begin
          emit_code({carry, 2'b00});
          emit(CHAR_PAD);
        end
        carry  = '0;
        phase  = PH_0;
        column = '0;
      end
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_char(logic [7:0] ch, logic last);
      char_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected character 0x%02h", ch));
      end else begin
        want = pending.pop_front();
        if (ch !== want.ch)
          report($sformatf("out_char 0x%02h, expected 0x%02h", ch, want.ch));
        if (last !== want.last)
          report($sformatf("last_of_run %b, expected %b (char 0x%02h)",
                           last, want.last, want.ch));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       line_length_we = 1'b0;
  logic [7:0] line_length_d = 8'd0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = 8'd0;
  logic       end_of_data = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char;
  logic       last_of_run;

  b64_scoreboard sb = new();
  bit  hold_req = 1'b0;
  bit  no_gaps  = 1'b0;
  int  burst_left = 0;
  int  idle_cycles = 0;

  base64_encoder_line_wrap dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .line_length_we_i(line_length_we),
    .line_length_i   (line_length_d),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte),
    .end_of_data_i   (end_of_data),
    .empty           (empty),
    .pop             (pop),
    .out_char_o      (out_char),
    .last_of_run_o   (last_of_run)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (line_length_we) sb.set_line_length(line_length_d);
      if (push && !full) sb.note_byte(data_byte, end_of_data);
      if (pop && !empty) sb.check_char(out_char, last_of_run);
      if ((push && !full) || (pop && !empty) || line_length_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_MAX) begin
          $display("[%0t] watchdog: no request moved for %0d cycles", $realtime, STALL_MAX);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // Receiver: stall pattern changes at random among four modes; a long hold-off on request
  initial begin
    pop_mode_e mode;
    int        mode_left;
    int        hold;
    bit        hold_seen;
    mode      = POP_ALWAYS;
    mode_left = 0;
    hold      = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_seen) begin
        hold      = LONG_HOLD;
        hold_seen = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = pop_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        case (mode)
          POP_ALWAYS: pop <= 1'b1;
          POP_RANDOM: pop <= 1'($urandom_range(0, 1));
          POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
          default:    pop <= ~pop;
        endcase
      end
    end
  end

  task send_byte(logic [7:0] b, logic eod);
    push        <= 1'b1;
    data_byte   <= b;
    end_of_data <= eod;
    do @(posedge clk_i); while (full);
  endtask

  // Bursts of random length with random gaps between them
  task pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : (($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                        : $urandom_range(0, 4));
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task write_line_length(logic [7:0] v);
    line_length_we <= 1'b1;
    line_length_d  <= v;
    @(posedge clk_i);
    line_length_we <= 1'b0;
  endtask

  initial begin
    int          budget;
    int          n;
    logic [7:0]  len;
    bit          paused;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default line length, pads after one and two bytes, '/'
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();

    // Shortest line: line feed ahead of the pads, six characters from one byte
    write_line_length(8'd1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b1);
    drain();

    // Zero length: line feed after every data character
    write_line_length(8'd0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    drain();

    // Longest line, then shrink it below the current column mid-stream
    write_line_length(8'd255);
    for (int i = 0; i < 9; i++) send_byte(8'hFC - 8'(i * 29), 1'b0);
    drain();
    write_line_length(8'd3);
    send_byte(8'h03, 1'b0);
    send_byte(8'hC4, 1'b1);
    drain();

    // Random streams, one line length per pass; a stream cut short by the
    // budget carries on into the next pass without its end flag
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       len = 8'd1;
        1:       len = 8'd255;
        2:       len = LINE_LENGTH_RESET;
        3:       len = 8'($urandom_range(2, 8));
        4:       len = 8'($urandom_range(9, 40));
        default: len = 8'($urandom_range(1, 255));
      endcase
      drain();
      write_line_length(len);
      no_gaps = (p == 2);
      if (p == 4) hold_req = 1'b1;
      paused = 1'b0;
      budget = 52;
      while (budget > 0) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        for (int k = 0; k < n && budget > 0; k++) begin
          pace();
          send_byte(8'($urandom_range(0, 255)), k == n - 1);
          budget--;
        end
        if (p == 5 && !paused) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d characters never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
